FILE: rtl/core/hbdu_pkg.sv
// ----------------------------------------------------------------------------
// hbdu_pkg
// Shared widths, coefficients and mu-law constants for the half-band
// decimator and mu-law encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbdu_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int ULAW_W    = 8;
	localparam int COEF_W    = 16;
	// worst-case |sum| is 32768 * sum(|coef|) < 2^31
	localparam int ACC_W     = 32;
	localparam int TAP_COUNT = 23;

	localparam int FRAC_BITS  = 15;
	localparam int ROUND_HALF = 1 << 14;
	localparam int MU_CLIP    = 32635;
	localparam int MU_BIAS    = 'h84;
	localparam int MU_MANT_W  = 4;
	localparam int MU_EXP_W   = 3;

	// Q15 half-band taps, symmetric about the center tap
	localparam logic signed [COEF_W-1:0] COEF_TABLE [TAP_COUNT] = '{
		-16'sd76,   16'sd0, 16'sd177,  16'sd0, -16'sd521,  16'sd0,
		16'sd1266,  16'sd0, -16'sd2932, 16'sd0, 16'sd10259,
		16'sd16422,
		16'sd10259, 16'sd0, -16'sd2932, 16'sd0, 16'sd1266,
		16'sd0, -16'sd521, 16'sd0, 16'sd177, 16'sd0, -16'sd76
	};

endpackage

`default_nettype wire

FILE: rtl/core/hbdu_sample_if.sv
// ----------------------------------------------------------------------------
// hbdu_sample_if
// Valid/ready channel carrying one signed PCM sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbdu_sample_if;
	import hbdu_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/hbdu_ulaw_if.sv
// ----------------------------------------------------------------------------
// hbdu_ulaw_if
// Valid/ready channel carrying one mu-law code per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbdu_ulaw_if;
	import hbdu_pkg::*;

	logic              valid;
	logic              ready;
	logic [ULAW_W-1:0] ulaw_byte;

	modport source (output valid, output ulaw_byte, input ready);
	modport sink   (input valid, input ulaw_byte, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/hbdu_tap_cell.sv
// ----------------------------------------------------------------------------
// hbdu_tap_cell
// One transposed-form FIR cell: multiplies the broadcast sample by its tap
// and adds the partial sum handed over from its upstream neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdu_tap_cell #(
	parameter logic signed [hbdu_pkg::COEF_W-1:0] COEF = '0
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic signed [hbdu_pkg::SAMPLE_W-1:0] x,
	input  wire logic signed [hbdu_pkg::ACC_W-1:0]    acc_in,
	output      logic signed [hbdu_pkg::ACC_W-1:0]    acc_q
);
	import hbdu_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_W;

	logic signed [PROD_W-1:0] prod;

	assign prod = x * COEF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= acc_in + ACC_W'(prod);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hbdu_ulaw_enc.sv
// ----------------------------------------------------------------------------
// hbdu_ulaw_enc
// Rounds and saturates the Q15 filter sum to 16 bits, then forms the
// complemented mu-law code.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdu_ulaw_enc (
	input  wire logic signed [hbdu_pkg::ACC_W-1:0] acc,
	output      logic [hbdu_pkg::ULAW_W-1:0]       code
);
	import hbdu_pkg::*;

	localparam int RS_W  = ACC_W + 1 - FRAC_BITS;
	localparam int MAG_W = SAMPLE_W;
	localparam int BIA_W = SAMPLE_W - 1;
	localparam logic signed [RS_W-1:0] SAT_HI = RS_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(-(1 << (SAMPLE_W - 1)));
	// biased magnitude top bit lies in [7, 14]
	localparam int EXP_BASE = 7;

	logic signed [ACC_W:0]      rnd;
	logic signed [RS_W-1:0]     rs;
	logic signed [SAMPLE_W-1:0] pcm;
	logic                       neg;
	logic [MAG_W:0]             mag_full;
	logic [MAG_W-1:0]           mag;
	logic [BIA_W-1:0]           biased;
	logic [MU_EXP_W-1:0]        expo;
	logic [BIA_W-1:0]           shifted;
	logic [MU_MANT_W-1:0]       mant;

	always_comb begin
		rnd = {acc[ACC_W-1], acc} + (ACC_W + 1)'(ROUND_HALF);
		rs  = rnd[ACC_W:FRAC_BITS];
		if (rs > SAT_HI) begin
			pcm = SAMPLE_W'(SAT_HI);
		end else if (rs < SAT_LO) begin
			pcm = SAMPLE_W'(SAT_LO);
		end else begin
			pcm = rs[SAMPLE_W-1:0];
		end

		neg = pcm[SAMPLE_W-1];
		if (neg) begin
			mag_full = (MAG_W + 1)'(0) - {pcm[SAMPLE_W-1], pcm};
		end else begin
			mag_full = {1'b0, pcm};
		end
		mag = mag_full[MAG_W-1:0];
		if (mag > MAG_W'(MU_CLIP)) begin
			mag = MAG_W'(MU_CLIP);
		end
		biased = mag[BIA_W-1:0] + BIA_W'(MU_BIAS);

		// highest set bit wins
		expo = '0;
		for (int b = EXP_BASE; b < BIA_W; b++) begin
			if (biased[b]) begin
				expo = MU_EXP_W'(b - EXP_BASE);
			end
		end
		shifted = biased >> (expo + 4'd3);
		mant    = shifted[MU_MANT_W-1:0];
		code    = ~{neg, expo, mant};
	end

endmodule

`default_nettype wire

FILE: rtl/core/halfband_decimator_ulaw_encoder_core.sv
// ----------------------------------------------------------------------------
// halfband_decimator_ulaw_encoder_core
// Half-band decimate-by-2 FIR as a chain of transposed-form tap cells,
// followed by a mu-law encoder and an output register.
// ----------------------------------------------------------------------------
// Path: the second sample of a pair is registered in the tap chain, and its code then in the output register.
// Throughput: one sample per cycle; a sample that completes a pair holds off
//   the next sample while the tap chain result moves to the output register,
//   and longer while that register is still full.
// Reset: arst_n clears the tap cell partial sums, the phase and all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module halfband_decimator_ulaw_encoder_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hbdu_sample_if.sink  samples,
	hbdu_ulaw_if.source  codes
);
	import hbdu_pkg::*;

	logic                    accept;
	logic                    phase_q;
	logic                    pend_s1;
	logic                    out_valid_q;
	logic [ULAW_W-1:0]       code_q;
	logic [ULAW_W-1:0]       enc_code;
	logic                    load_out;
	logic signed [ACC_W-1:0] part [TAP_COUNT];

	assign samples.ready = !pend_s1;
	assign accept        = samples.valid && samples.ready;
	assign load_out      = pend_s1 && (!out_valid_q || codes.ready);

	// cell k holds the partial sum of taps k..TAP_COUNT-1; cell 0 is the output
	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
		logic signed [ACC_W-1:0] acc_in;
		if (k == TAP_COUNT - 1) begin : g_last
			assign acc_in = '0;
		end else begin : g_mid
			assign acc_in = part[k+1];
		end
		hbdu_tap_cell #(
			.COEF(COEF_TABLE[TAP_COUNT-1-k])
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.x      (samples.sample),
			.acc_in (acc_in),
			.acc_q  (part[k])
		);
	end

	hbdu_ulaw_enc u_enc (
		.acc  (part[0]),
		.code (enc_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= !phase_q;
			end
			// second sample of a pair: chain head now holds a filter word
			if (accept && phase_q) begin
				pend_s1 <= 1'b1;
			end else if (load_out) begin
				pend_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (codes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			code_q <= enc_code;
		end
	end

	assign codes.valid     = out_valid_q;
	assign codes.ulaw_byte = code_q;

endmodule

`default_nettype wire
